// File: hw/rtl/mouse_keys_accelerated_pointer_top_macros.svh
// Assertion macros used by the mouse-keys pointer back end (mkap_back).
`ifndef MOUSE_KEYS_ACCELERATED_POINTER_TOP_MACROS_SVH
`define MOUSE_KEYS_ACCELERATED_POINTER_TOP_MACROS_SVH

// Clocked property with asynchronous active-low reset disable.
`define MKAP_CHECK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("mkap check failed");

// Expression that must never be true while out of reset.
`define MKAP_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("mkap forbidden condition seen");

`endif

// File: hw/rtl/mkap_pkg.sv
// Shared types and constants of the mouse-keys pointer block.
`timescale 1ns / 1ps
package mkap_pkg;

	localparam int unsigned MKAP_QUEUE_DEPTH = 2;
	localparam logic [31:0] DEFAULT_THRESHOLD = 32'd150000000;

	localparam logic [7:0] SC_MODE      = 8'hA3;
	localparam logic [7:0] SC_RIGHT     = 8'hB7;
	localparam logic [7:0] SC_LEFT      = 8'hB4;
	localparam logic [7:0] SC_DOWN      = 8'hB6;
	localparam logic [7:0] SC_UP        = 8'hB5;
	localparam logic [7:0] SC_BTN_LEFT  = 8'h5D;
	localparam logic [7:0] SC_BTN_RIGHT = 8'h5B;

	localparam logic [2:0] ST_PRESSED  = 3'd1;
	localparam logic [2:0] ST_HOLD     = 3'd2;
	localparam logic [2:0] ST_RELEASED = 3'd3;

	localparam logic [3:0] DIR_LEFT  = 4'b0001;
	localparam logic [3:0] DIR_RIGHT = 4'b0010;
	localparam logic [3:0] DIR_UP    = 4'b0100;
	localparam logic [3:0] DIR_DOWN  = 4'b1000;

	localparam logic [1:0] KIND_KEY    = 2'd0;
	localparam logic [1:0] KIND_BUTTON = 2'd1;
	localparam logic [1:0] KIND_MOVE   = 2'd2;
	localparam logic [1:0] KIND_SYNC   = 2'd3;

	// One queued job: a tick, or a single key/button result.
	typedef struct packed {
		logic        tick;
		logic [3:0]  dirs;
		logic [63:0] elapsed;
		logic [1:0]  kind;
		logic [7:0]  code;
		logic        pressed;
		logic        btn;
	} job_t;

endpackage

// File: hw/rtl/mkap_front.sv
// Front end: accepts beats, tracks mode, directions and press timer, queues jobs.
`timescale 1ns / 1ps
module mkap_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          command,
	input  logic [2:0]    key_state,
	input  logic [7:0]    scancode,
	input  logic [63:0]   time_ns,
	input  logic          full,
	output logic          push,
	output mkap_pkg::job_t push_job
);
	import mkap_pkg::*;

	logic        mode_q, mode_d;
	logic [3:0]  held_q, held_d;
	logic [63:0] pst_q, pst_d;
	logic        accept;
	logic        st_ok;
	logic [3:0]  dir_bit;
	logic        is_btn;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;
	assign st_ok    = (key_state == ST_PRESSED) || (key_state == ST_HOLD) ||
	                  (key_state == ST_RELEASED);
	assign is_btn   = (scancode == SC_BTN_LEFT) || (scancode == SC_BTN_RIGHT);

	always_comb begin
		unique case (scancode)
			SC_LEFT:  dir_bit = DIR_LEFT;
			SC_RIGHT: dir_bit = DIR_RIGHT;
			SC_UP:    dir_bit = DIR_UP;
			SC_DOWN:  dir_bit = DIR_DOWN;
			default:  dir_bit = 4'b0000;
		endcase
	end

	always_comb begin
		mode_d           = mode_q;
		held_d           = held_q;
		pst_d            = pst_q;
		push             = 1'b0;
		push_job.tick    = 1'b0;
		push_job.dirs    = mode_q ? held_q : 4'b0000;
		push_job.elapsed = time_ns - pst_q;
		push_job.kind    = KIND_KEY;
		push_job.code    = scancode;
		push_job.pressed = (key_state == ST_PRESSED);
		push_job.btn     = 1'b0;
		if (accept) begin
			if (command) begin
				push             = 1'b1;
				push_job.tick    = 1'b1;
				push_job.kind    = KIND_SYNC;
				push_job.code    = 8'h00;
				push_job.pressed = 1'b0;
			end else if (st_ok) begin
				if (scancode == SC_MODE) begin
					if (key_state == ST_PRESSED) begin
						mode_d = !mode_q;
					end
				end else if (mode_q && (dir_bit != 4'b0000)) begin
					if (key_state == ST_PRESSED) begin
						// restart the timer only on a fresh direction
						if ((held_q & dir_bit) == 4'b0000) begin
							pst_d = time_ns;
						end
						held_d = held_q | dir_bit;
					end else if (key_state == ST_RELEASED) begin
						if (scancode == SC_LEFT) begin
							pst_d = time_ns;
						end
						held_d = held_q & ~dir_bit;
					end
				end else if (mode_q && is_btn) begin
					push          = 1'b1;
					push_job.kind = KIND_BUTTON;
					push_job.code = 8'h00;
					push_job.btn  = (scancode == SC_BTN_RIGHT);
				end else begin
					// passthrough: hold restarts the timer but drops the beat
					pst_d = time_ns;
					push  = (key_state != ST_HOLD);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			held_q <= 4'b0000;
			pst_q  <= 64'd0;
		end else begin
			mode_q <= mode_d;
			held_q <= held_d;
			pst_q  <= pst_d;
		end
	end

endmodule

// File: hw/rtl/mkap_queue.sv
// Small job queue between the front end and the result sequencer.
`timescale 1ns / 1ps
module mkap_queue #(
	parameter int unsigned DEPTH = mkap_pkg::MKAP_QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mkap_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output mkap_pkg::job_t head
);
	import mkap_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == FULL_CNT);
	assign valid   = (count_q != '0);
	assign head    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: hw/rtl/mkap_back.sv
// Back end: expands queued jobs into result beats behind an output register.
`timescale 1ns / 1ps
`include "mouse_keys_accelerated_pointer_top_macros.svh"
module mkap_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [31:0]   threshold,
	input  logic          job_valid,
	input  mkap_pkg::job_t job,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    out_kind,
	output logic [7:0]    out_code,
	output logic          out_pressed,
	output logic          out_btn,
	output logic          out_axis,
	output logic signed [3:0] out_delta,
	output logic          out_last
);
	import mkap_pkg::*;

	job_t        cur_q;
	logic        cur_valid_q;
	logic [4:0]  pend_q;   // left, right, down, up, final
	logic [2:0]  step_q;
	logic [2:0]  step_d;
	logic [4:0]  pend_init;
	logic [4:0]  pick, rem;
	logic        pick_last;
	logic        advance, load;
	logic [33:0] thr3;
	logic [3:0]  mag;
	logic        neg;

	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [7:0]  out_code_q;
	logic        out_pressed_q, out_btn_q, out_axis_q, out_last_q;
	logic [3:0]  out_delta_q;

	assign thr3 = {2'b00, threshold} + {1'b0, threshold, 1'b0};

	always_comb begin
		if (job.elapsed <= {32'd0, threshold}) begin
			step_d = 3'd1;
		end else if ((job.elapsed[63:34] == 30'd0) && (job.elapsed[33:0] <= thr3)) begin
			step_d = 3'd2;
		end else begin
			step_d = 3'd4;
		end
	end

	assign pend_init = job.tick ? {1'b1, job.dirs[2], job.dirs[3], job.dirs[1], job.dirs[0]}
	                            : 5'b10000;

	// lowest pending result goes next
	assign pick      = pend_q & (~pend_q + 5'd1);
	assign rem       = pend_q & ~pick;
	assign pick_last = (rem == 5'b00000);
	assign advance   = cur_valid_q && (!out_valid_q || out_ready);
	assign load      = job_valid && (!cur_valid_q || (advance && pick_last));
	assign pop       = load;

	assign mag = {1'b0, step_q};
	assign neg = pick[0] || pick[3];

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q  <= job;
			step_q <= step_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pend_q      <= 5'b00000;
		end else if (load) begin
			cur_valid_q <= 1'b1;
			pend_q      <= pend_init;
		end else if (advance) begin
			pend_q <= rem;
			if (pick_last) begin
				cur_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_last_q <= pick_last;
			if (pick[4]) begin
				out_kind_q    <= cur_q.kind;
				out_code_q    <= cur_q.code;
				out_pressed_q <= cur_q.pressed;
				out_btn_q     <= cur_q.btn;
				out_axis_q    <= 1'b0;
				out_delta_q   <= 4'd0;
			end else begin
				out_kind_q    <= KIND_MOVE;
				out_code_q    <= 8'h00;
				out_pressed_q <= 1'b0;
				out_btn_q     <= 1'b0;
				out_axis_q    <= pick[2] || pick[3];
				out_delta_q   <= neg ? (~mag + 4'd1) : mag;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_kind    = out_kind_q;
	assign out_code    = out_code_q;
	assign out_pressed = out_pressed_q;
	assign out_btn     = out_btn_q;
	assign out_axis    = out_axis_q;
	assign out_delta   = out_delta_q;
	assign out_last    = out_last_q;

	`MKAP_CHECK(a_pend_live, clk, arst_n, cur_valid_q |-> (pend_q != 5'b00000))
	`MKAP_CHECK(a_pick_one, clk, arst_n, cur_valid_q |-> $onehot(pick))
	`MKAP_CHECK(a_sync_last, clk, arst_n, (out_valid_q && (out_kind_q == KIND_SYNC)) |-> out_last_q)
	`MKAP_NEVER(a_move_last, clk, arst_n, out_valid_q && (out_kind_q == KIND_MOVE) && out_last_q)

endmodule

// File: hw/rtl/mouse_keys_accelerated_pointer_top.sv
// Top level of the mouse-keys pointer emulator: ports, threshold register, wiring.
//
// channel  dir  handshake            payload
// s_*      in   s_tvalid/s_tready    tuser command, tdata key event and time
// m_*      out  m_tvalid/m_tready    tuser kind, tdata result, tlast end of item
// cfg_*    in   cfg_valid/cfg_ready  fast_move_threshold, 32 bit
//
// A beat is taken in any cycle the job queue has room; key events without a
// result leave nothing queued. The result sequencer gives one result beat per
// cycle unless m_tready stalls it: a tick in mouse mode with n held directions
// gives n + 1 beats, other jobs one. The job queue and output register let the
// front keep accepting while a result waits on m_tready, until the queue fills.
// Reset clears mode, directions, timer and queue and loads the threshold with 150000000.
`timescale 1ns / 1ps
module mouse_keys_accelerated_pointer_top #(
	parameter int unsigned QUEUE_DEPTH = mkap_pkg::MKAP_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // key_state[2:0], scancode[10:3], time_ns[74:11], zero
	input  logic        s_tuser,  // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // key_code[7:0], key_pressed[8], button_select[9],
	                              // move_axis[10], move_delta[14:11], zero[15]
	output logic [1:0]  m_tuser,  // kind
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	import mkap_pkg::*;

	logic [31:0]       thr_q;
	logic              push, full, pop, job_valid;
	job_t              push_job, head;
	logic [7:0]        out_code;
	logic              out_pressed, out_btn, out_axis;
	logic signed [3:0] out_delta;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= DEFAULT_THRESHOLD;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	mkap_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.command   (s_tuser),
		.key_state (s_tdata[2:0]),
		.scancode  (s_tdata[10:3]),
		.time_ns   (s_tdata[74:11]),
		.full      (full),
		.push      (push),
		.push_job  (push_job)
	);

	mkap_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.valid    (job_valid),
		.head     (head)
	);

	mkap_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.threshold   (thr_q),
		.job_valid   (job_valid),
		.job         (head),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_kind    (m_tuser),
		.out_code    (out_code),
		.out_pressed (out_pressed),
		.out_btn     (out_btn),
		.out_axis    (out_axis),
		.out_delta   (out_delta),
		.out_last    (m_tlast)
	);

	assign m_tdata = {1'b0, out_delta, out_axis, out_btn, out_pressed, out_code};

endmodule
